/* hdl/psr_pkg.sv */
// Package for the pitch-shifting linear resampler.
// Holds field widths, register and mode codes, the semitone table and the store request type.
// No dependencies.
package psr_pkg;

    localparam int SAMPLE_DEPTH = 65536;
    localparam int STEP_FRAC    = 24;

    localparam int ADDR_W    = $clog2(SAMPLE_DEPTH);
    localparam int NOTE_W    = 7;
    localparam int CNT_W     = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int ADR_FLD_W = 16;
    localparam int SMP_W     = 16;
    localparam int IDX_W     = 24;
    localparam int VAL_W     = SMP_W + 8;
    localparam int IN_DATA_W = ADR_FLD_W + SMP_W + IDX_W;

    localparam int STEP_W    = 40;
    localparam int HALF_W    = STEP_W / 2;
    localparam int PART_W    = IDX_W + HALF_W;
    localparam int POS_W     = IDX_W + STEP_W;
    localparam int LOW_W     = POS_W - STEP_FRAC;
    localparam int ACC_W     = SMP_W + STEP_FRAC + 2;

    localparam int SEMI_W    = 17;
    localparam int SEMI_FRAC = 16;

    localparam logic [NOTE_W-1:0] NOTE_RESET = NOTE_W'(60);
    localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = CFG_IDX_W'(2);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [SMP_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
    } t_store_req;

    // 2^(s/12) in Q1.16, rounded to nearest
    function automatic logic [SEMI_W-1:0] semitone(input logic [3:0] s);
        logic [SEMI_W-1:0] v;
        unique case (s)
            4'd0:    v = SEMI_W'(65536);
            4'd1:    v = SEMI_W'(69433);
            4'd2:    v = SEMI_W'(73562);
            4'd3:    v = SEMI_W'(77936);
            4'd4:    v = SEMI_W'(82570);
            4'd5:    v = SEMI_W'(87480);
            4'd6:    v = SEMI_W'(92682);
            4'd7:    v = SEMI_W'(98193);
            4'd8:    v = SEMI_W'(104032);
            4'd9:    v = SEMI_W'(110218);
            4'd10:   v = SEMI_W'(116772);
            4'd11:   v = SEMI_W'(123715);
            default: v = SEMI_W'(65536);
        endcase
        return v;
    endfunction

endpackage

/* hdl/psr_step.sv */
// Pitch step generator: 0.5 * 2^((target - root) / 12) in unsigned fixed point.
// Semitone table lookup plus rounding shift, saturated, registered.
// Depends on psr_pkg.
module psr_step import psr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [NOTE_W-1:0] i_root_note,
    input  logic [NOTE_W-1:0] i_target_note,
    output logic [STEP_W-1:0] o_step
);

    localparam int OCT_BIAS = 11;
    localparam int EXP_OFS  = STEP_FRAC - SEMI_FRAC - OCT_BIAS - 1;
    localparam int WIDE_W   = (STEP_FRAC + 10 > STEP_W) ? STEP_FRAC + 10 : STEP_W + 1;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << (STEP_FRAC - 1);

    logic [8:0]          w_bias;
    logic [18:0]         w_recip;
    logic [4:0]          w_oct;
    logic [3:0]          w_semi;
    logic [SEMI_W-1:0]   w_base;
    logic signed [7:0]   w_exp;
    logic [6:0]          w_sh;
    logic [WIDE_W-1:0]   w_wide;
    logic [STEP_W-1:0]   n_step;
    logic [STEP_W-1:0]   r_step;

    always_comb begin
        // difference biased by whole octaves so that the floor division works on a positive value
        w_bias  = 9'(i_target_note) + 9'(OCT_BIAS * 12) - 9'(i_root_note);
        w_recip = 19'(w_bias) * 19'd683;
        w_oct   = w_recip[17:13];
        w_semi  = 4'(w_bias - 9'(w_oct) * 9'd12);
        w_base  = semitone(w_semi);
        w_exp   = $signed({3'b000, w_oct}) + 8'(EXP_OFS);
        w_sh    = 7'(-w_exp);
        if (w_exp >= 0) begin
            w_wide = WIDE_W'(w_base) << w_exp[6:0];
        end else begin
            w_wide = (WIDE_W'(w_base) + (WIDE_W'(1) << (w_sh - 7'd1))) >> w_sh;
        end
        n_step = (|w_wide[WIDE_W-1:STEP_W]) ? '1 : w_wide[STEP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_step = r_step;

endmodule

/* hdl/psr_store.sv */
// Sample store: one write port and two registered read ports.
// Contents are undefined until written.
// Depends on psr_pkg.
module psr_store import psr_pkg::*; (
    input  logic             i_clk,
    input  t_store_req       i_req,
    output logic [SMP_W-1:0] o_rd_a,
    output logic [SMP_W-1:0] o_rd_b
);

    logic [SMP_W-1:0] r_mem [SAMPLE_DEPTH];
    logic [SMP_W-1:0] r_rd_a;
    logic [SMP_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_a <= r_mem[i_req.rd_addr_a];
            r_rd_b <= r_mem[i_req.rd_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

/* hdl/pitch_shift_linear_resampler.sv */
// Pitch-shifting linear-interpolation resampler with a 64K x 16 sample store.
// Input stream: tuser = mode (0 load, 1 read); tdata = address, sample, out_index.
// Load transfers write one sample and give no result. Read transfers give one
// result: tdata = interpolated value (raw sample units, 8 fraction bits),
// tuser = past_end (then value is zero).
// The position is out_index times the pitch step; the step follows root_note and
// target_note, written on the configuration port, via the note registers and the step register.
// Configure only while no transfer is in flight.
// Throughput: one transfer per cycle while the output is not stalled. Stages:
// input register, two split multipliers, position add, address and end check,
// store read, interpolation multiplier, output.
// Reset: synchronous, active low; clears the pipeline, sets both notes to 60,
// sample_count to 1 and the step to 0.5. The store is not cleared.
// A stalled output freezes the whole pipeline and drops o_s_axis_tready;
// nothing is lost or repeated.
// Depends on psr_pkg, psr_step, psr_store.
module pitch_shift_linear_resampler import psr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_DATA_W-1:0] i_s_axis_tdata,   // address[15:0], sample[31:16], out_index[55:32]
    input  logic                 i_s_axis_tuser,   // mode
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [VAL_W-1:0]     o_m_axis_tdata,   // value[23:0]
    output logic                 o_m_axis_tuser    // past_end
);

    logic [NOTE_W-1:0] r_root;
    logic [NOTE_W-1:0] r_target;
    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  n_used;
    logic [STEP_W-1:0] w_step;
    logic              w_adv;

    logic                 r0_vld, r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic                 r0_mode, r1_mode, r2_mode, r3_mode;
    logic [ADR_FLD_W-1:0] r0_addr, r1_addr, r2_addr, r3_addr;
    logic [SMP_W-1:0]     r0_sample, r1_sample, r2_sample, r3_sample;
    logic [IDX_W-1:0]     r0_idx;
    logic [PART_W-1:0]    r1_plo, r1_phi;
    logic [POS_W-1:0]     r2_pos;
    logic                 r3_past, r4_past, r5_past;
    logic [STEP_FRAC-1:0] r3_frac, r4_frac;
    logic [ADDR_W-1:0]    r3_addr_a, r3_addr_b;
    logic [SMP_W-1:0]     r5_a;
    logic signed [ACC_W-1:0] r5_prod;
    logic                 r_out_vld;
    logic [VAL_W-1:0]     r_out_value;
    logic                 r_out_past;

    logic [LOW_W-1:0]     w_lower;
    logic                 w_past;
    logic                 w_at_last;
    logic [ADDR_W-1:0]    w_addr_a;
    logic [ADDR_W-1:0]    w_addr_b;
    t_store_req           w_req;
    logic [SMP_W-1:0]     w_rd_a, w_rd_b;
    logic [SMP_W-1:0]     w_a, w_b;
    logic signed [SMP_W:0] w_diff;
    logic signed [ACC_W-1:0] w_prod;
    logic signed [ACC_W-1:0] w_acc;
    logic [VAL_W-1:0]     w_val;

    localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (STEP_FRAC - 9);

    // configuration
    always_comb begin
        n_used = (32'(i_cfg_data) > SAMPLE_DEPTH) ? CNT_W'(SAMPLE_DEPTH) : CNT_W'(i_cfg_data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root   <= NOTE_RESET;
            r_target <= NOTE_RESET;
            r_used   <= CNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROOT:   r_root   <= i_cfg_data[NOTE_W-1:0];
                CFG_TARGET: r_target <= i_cfg_data[NOTE_W-1:0];
                CFG_COUNT:  r_used   <= n_used;
                default: ;
            endcase
        end
    end

    psr_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_root_note   (r_root),
        .i_target_note (r_target),
        .o_step        (w_step)
    );

    // advance the whole pipeline unless the output is held
    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // end check and neighbour address
    always_comb begin
        w_lower   = r2_pos[POS_W-1:STEP_FRAC];
        w_past    = w_lower >= LOW_W'(r_used);
        w_at_last = (w_lower + LOW_W'(1)) == LOW_W'(r_used);
        w_addr_a  = ADDR_W'(w_lower);
        w_addr_b  = w_at_last ? w_addr_a : w_addr_a + ADDR_W'(1);
    end

    always_comb begin
        w_req.wr_en     = w_adv && r3_vld && (r3_mode == MODE_LOAD)
                          && (32'(r3_addr) < SAMPLE_DEPTH);
        w_req.wr_addr   = ADDR_W'(r3_addr);
        w_req.wr_data   = r3_sample;
        w_req.rd_en     = w_adv && r3_vld && (r3_mode == MODE_READ);
        w_req.rd_addr_a = r3_addr_a;
        w_req.rd_addr_b = r3_addr_b;
    end

    psr_store u_store (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_rd_a (w_rd_a),
        .o_rd_b (w_rd_b)
    );

    // interpolation on offset-binary samples
    always_comb begin
        w_a    = {~w_rd_a[SMP_W-1], w_rd_a[SMP_W-2:0]};
        w_b    = {~w_rd_b[SMP_W-1], w_rd_b[SMP_W-2:0]};
        w_diff = $signed({1'b0, w_b}) - $signed({1'b0, w_a});
        w_prod = ACC_W'(w_diff * $signed({1'b0, r4_frac}));
        w_acc  = $signed({2'b00, r5_a, {STEP_FRAC{1'b0}}}) + r5_prod + $signed(RND);
        w_val  = w_acc[STEP_FRAC+SMP_W-1:STEP_FRAC-8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld    <= 1'b0;
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r0_vld    <= i_s_axis_tvalid;
            r1_vld    <= r0_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld && (r3_mode == MODE_READ);
            r5_vld    <= r4_vld;
            r_out_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_mode   <= i_s_axis_tuser;
            r0_addr   <= i_s_axis_tdata[ADR_FLD_W-1:0];
            r0_sample <= i_s_axis_tdata[ADR_FLD_W+SMP_W-1:ADR_FLD_W];
            r0_idx    <= i_s_axis_tdata[IN_DATA_W-1:ADR_FLD_W+SMP_W];

            r1_mode   <= r0_mode;
            r1_addr   <= r0_addr;
            r1_sample <= r0_sample;
            r1_plo    <= PART_W'(r0_idx) * PART_W'(w_step[HALF_W-1:0]);
            r1_phi    <= PART_W'(r0_idx) * PART_W'(w_step[STEP_W-1:HALF_W]);

            r2_mode   <= r1_mode;
            r2_addr   <= r1_addr;
            r2_sample <= r1_sample;
            r2_pos    <= POS_W'(r1_plo) + (POS_W'(r1_phi) << HALF_W);

            r3_mode   <= r2_mode;
            r3_addr   <= r2_addr;
            r3_sample <= r2_sample;
            r3_past   <= w_past;
            r3_frac   <= r2_pos[STEP_FRAC-1:0];
            r3_addr_a <= w_addr_a;
            r3_addr_b <= w_addr_b;

            r4_past   <= r3_past;
            r4_frac   <= r3_frac;

            r5_past   <= r4_past;
            r5_a      <= w_a;
            r5_prod   <= w_prod;

            r_out_past  <= r5_past;
            r_out_value <= r5_past ? '0 : {~w_val[VAL_W-1], w_val[VAL_W-2:0]};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_past;

`ifndef NO_ASSERTIONS
    a_past_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("past-end result carries a nonzero value");

    a_store_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_req.wr_en && w_req.rd_en))
        else $error("store written and read by one stage in the same cycle");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r5_vld && w_adv))
        else $error("result raised without a read item in the last stage");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r3_vld) && $stable(r3_addr_a) && $stable(r4_vld))
        else $error("pipeline moved while the output was stalled");
`endif

endmodule
